// ===== rtl/core/telnet_rx_option_negotiator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Telnet RX option negotiator - assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef TELNET_RX_OPTION_NEGOTIATOR_CORE_MACROS_SVH
`define TELNET_RX_OPTION_NEGOTIATOR_CORE_MACROS_SVH

// check a condition at every clock edge
`define TNRX_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// check that a condition implies another in the same cycle
`define TNRX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tnrx_pkg.sv =====
// ----------------------------------------------------------------------------
// Telnet RX option negotiator - package
// Byte codes, parser states, job descriptor and word generation helpers.
// ----------------------------------------------------------------------------
package tnrx_pkg;

    localparam logic [7:0] B_IAC  = 8'hFF;
    localparam logic [7:0] B_DONT = 8'hFE;
    localparam logic [7:0] B_DO   = 8'hFD;
    localparam logic [7:0] B_WONT = 8'hFC;
    localparam logic [7:0] B_WILL = 8'hFB;
    localparam logic [7:0] B_SB   = 8'hFA;
    localparam logic [7:0] B_SE   = 8'hF0;
    localparam logic [7:0] O_NAWS = 8'h1F;
    localparam logic [7:0] O_ECHO = 8'h01;
    localparam logic [7:0] O_SGA  = 8'h03;

    localparam int          CFG_AW       = 1;
    localparam logic [0:0]  CFG_IDX_COLS = 1'b0;
    localparam logic [0:0]  CFG_IDX_ROWS = 1'b1;
    localparam logic [15:0] COLS_RESET   = 16'd80;
    localparam logic [15:0] ROWS_RESET   = 16'd24;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_RESIZE = 2'd1,
        KIND_START  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PS_DATA  = 3'd0,
        PS_IAC   = 3'd1,
        PS_CMD   = 3'd2,
        PS_SBHD  = 3'd3,
        PS_SBDAT = 3'd4,
        PS_SBIAC = 3'd5
    } t_pstate;

    typedef enum logic [1:0] {
        JOB_DATA       = 2'd0,
        JOB_REPLY      = 2'd1,
        JOB_SIZE       = 2'd2,
        JOB_REPLY_SIZE = 2'd3
    } t_job_op;

    typedef struct packed {
        t_job_op    op;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_job;

    function automatic logic [3:0] job_len(input t_job_op op);
        logic [3:0] len;
        unique case (op)
            JOB_DATA:       len = 4'd1;
            JOB_REPLY:      len = 4'd3;
            JOB_SIZE:       len = 4'd9;
            JOB_REPLY_SIZE: len = 4'd12;
            default:        len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] size_byte(input logic [3:0] idx,
                                             input logic [15:0] cols,
                                             input logic [15:0] rows);
        logic [7:0] b;
        case (idx)
            4'd0:    b = B_IAC;
            4'd1:    b = B_SB;
            4'd2:    b = O_NAWS;
            4'd3:    b = cols[15:8];
            4'd4:    b = cols[7:0];
            4'd5:    b = rows[15:8];
            4'd6:    b = rows[7:0];
            4'd7:    b = B_IAC;
            4'd8:    b = B_SE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/telnet_rx_option_negotiator_core.sv =====
// ----------------------------------------------------------------------------
// Telnet RX option negotiator - top level
// Received words enter on the slave stream; terminal data and negotiation
// replies leave on the master stream, tuser high for words bound to the wire.
// A word is accepted every cycle while the four-entry job queue has room; a
// plain data word passes the job queue and output register, which sends one
// word per cycle unless the master stream stalls. Replies are 3, 9 or 12 words
// (option reply, window size, DO NAWS answer); parsing goes on until the queue
// fills. Write size registers only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module telnet_rx_option_negotiator_core import tnrx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] rx_byte
    input  logic [1:0]        i_s_tuser,   // [1:0] kind
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [7:0] out_byte
    output logic              o_m_tuser,   // [0] to_wire
    output logic              o_m_tlast
);

    logic [15:0] r_cols, r_rows;
    logic        push, pop, full, empty;
    t_job        job, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_IDX_COLS) begin
                r_cols <= i_cfg_wdata;
            end
            if (i_cfg_addr == CFG_IDX_ROWS) begin
                r_rows <= i_cfg_wdata;
            end
        end
    end

    tnrx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (full),
        .o_push     (push),
        .o_job      (job)
    );

    tnrx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    tnrx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .i_cols     (r_cols),
        .i_rows     (r_rows),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== rtl/core/tnrx_front.sv =====
// ----------------------------------------------------------------------------
// Telnet RX option negotiator - front end
// Parses received words, strips commands and turns each item into a job.
// ----------------------------------------------------------------------------
module tnrx_front import tnrx_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic [1:0] i_s_tuser,   // [1:0] kind
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    t_pstate    r_state, n_state;
    logic [7:0] r_pending, n_pending;
    logic       r_naws, n_naws;
    logic       accept;
    logic       job_v;
    t_job       job;

    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && !i_full;
    assign o_push     = accept && job_v;
    assign o_job      = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= PS_DATA;
            r_pending <= 8'h00;
            r_naws    <= 1'b0;
        end else if (accept) begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_naws    <= n_naws;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_naws    = r_naws;
        job_v     = 1'b0;
        job       = '{op: JOB_DATA, b0: i_s_tdata, b1: i_s_tdata};
        unique case (t_kind'(i_s_tuser))
            KIND_RESIZE: begin
                job_v  = r_naws;
                job.op = JOB_SIZE;
            end
            KIND_START: begin
                n_state   = PS_DATA;
                n_pending = 8'h00;
                n_naws    = 1'b0;
                job_v     = 1'b1;
                job       = '{op: JOB_REPLY, b0: B_WILL, b1: O_NAWS};
            end
            KIND_BYTE: begin
                unique case (r_state)
                    PS_IAC: begin
                        if (i_s_tdata == B_IAC) begin
                            job_v   = 1'b1;
                            n_state = PS_DATA;
                        end else if (i_s_tdata == B_SB) begin
                            n_state = PS_SBHD;
                        end else if (i_s_tdata == B_DO || i_s_tdata == B_DONT ||
                                     i_s_tdata == B_WILL || i_s_tdata == B_WONT) begin
                            n_pending = i_s_tdata;
                            n_state   = PS_CMD;
                        end else begin
                            n_state = PS_DATA;
                        end
                    end
                    PS_CMD: begin
                        n_state = PS_DATA;
                        job.op  = JOB_REPLY;
                        case (r_pending)
                            B_DO: begin
                                job_v = 1'b1;
                                if (i_s_tdata == O_NAWS) begin
                                    job.op = JOB_REPLY_SIZE;
                                    job.b0 = B_WILL;
                                    n_naws = 1'b1;
                                end else begin
                                    job.b0 = B_WONT;
                                end
                            end
                            B_WILL: begin
                                job_v  = 1'b1;
                                job.b0 = (i_s_tdata == O_ECHO || i_s_tdata == O_SGA) ?
                                         B_DO : B_DONT;
                            end
                            B_DONT: begin
                                job_v  = 1'b1;
                                job.b0 = B_WONT;
                            end
                            B_WONT: begin
                                job_v  = 1'b1;
                                job.b0 = B_DONT;
                            end
                            default: job_v = 1'b0;
                        endcase
                    end
                    PS_SBHD:  n_state = PS_SBDAT;
                    PS_SBDAT: begin
                        if (i_s_tdata == B_IAC) begin
                            n_state = PS_SBIAC;
                        end
                    end
                    PS_SBIAC: n_state = (i_s_tdata == B_IAC) ? PS_SBDAT : PS_DATA;
                    default: begin
                        if (i_s_tdata == B_IAC) begin
                            n_state = PS_IAC;
                        end else begin
                            n_state = PS_DATA;
                            job_v   = 1'b1;
                        end
                    end
                endcase
            end
            default: job_v = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/tnrx_fifo.sv =====
// ----------------------------------------------------------------------------
// Telnet RX option negotiator - job queue
// Short register queue between the front end and the word generator.
// ----------------------------------------------------------------------------
`include "telnet_rx_option_negotiator_core_macros.svh"

module tnrx_fifo import tnrx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CW-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    `TNRX_ASSERT_IMP(a_no_push_full, i_push, !o_full, "job pushed into full queue")
    `TNRX_ASSERT(a_cnt_range, r_cnt <= FIFO_CW'(FIFO_DEPTH), "queue count out of range")

endmodule

// ===== rtl/core/tnrx_back.sv =====
// ----------------------------------------------------------------------------
// Telnet RX option negotiator - word generator
// Expands queued jobs into terminal and wire words through an output register.
// ----------------------------------------------------------------------------
`include "telnet_rx_option_negotiator_core_macros.svh"

module tnrx_back import tnrx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    input  logic [15:0] i_cols,
    input  logic [15:0] i_rows,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // [7:0] out_byte
    output logic        o_m_tuser,  // [0] to_wire
    output logic        o_m_tlast
);

    logic [3:0] r_cnt;
    logic       r_valid;
    logic [7:0] r_data;
    logic       r_wire;
    logic       r_last;
    logic       out_free;
    logic       emit;
    logic [3:0] len;
    logic       is_last;
    logic [7:0] word;

    assign out_free = !r_valid || i_m_tready;
    assign emit     = !i_empty && out_free;
    assign len      = job_len(i_head.op);
    assign is_last  = (r_cnt == len - 4'd1);
    assign o_pop    = emit && is_last;

    always_comb begin
        case (i_head.op)
            JOB_DATA:  word = i_head.b0;
            JOB_REPLY: word = (r_cnt == 4'd0) ? B_IAC :
                              (r_cnt == 4'd1) ? i_head.b0 : i_head.b1;
            JOB_SIZE:  word = size_byte(r_cnt, i_cols, i_rows);
            default: begin
                if (r_cnt == 4'd0) begin
                    word = B_IAC;
                end else if (r_cnt == 4'd1) begin
                    word = i_head.b0;
                end else if (r_cnt == 4'd2) begin
                    word = i_head.b1;
                end else begin
                    word = size_byte(r_cnt - 4'd3, i_cols, i_rows);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 4'd0;
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
            r_cnt   <= is_last ? 4'd0 : r_cnt + 4'd1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_data <= word;
            r_wire <= (i_head.op != JOB_DATA);
            r_last <= is_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_wire;
    assign o_m_tlast  = r_last;

    `TNRX_ASSERT_IMP(a_idle_cnt, i_empty, r_cnt == 4'd0, "word index set with no job")
    `TNRX_ASSERT_IMP(a_cnt_in_job, !i_empty, r_cnt < len, "word index past job length")
    `TNRX_ASSERT_IMP(a_term_last, r_valid && !r_wire, r_last, "terminal word not last")

endmodule

// ===== test/telnet_rx_negotiation_checker.sv =====
// ----------------------------------------------------------------------------
// Telnet RX option negotiator - stream checker
// Watches the configuration port and both streams of the core. Every received
// word is run through a bit-true copy of the telnet parser and reply policy,
// the bytes it should produce are queued, and each word leaving the master
// stream is compared against the oldest queued byte.
// ----------------------------------------------------------------------------
module telnet_rx_negotiation_checker import tnrx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] rx_byte
    input  logic [1:0]        i_s_tuser,   // [1:0] kind
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [7:0]        i_m_tdata,   // [7:0] out_byte
    input  logic              i_m_tuser,   // [0] to_wire
    input  logic              i_m_tlast,
    output int                o_due_count,
    output int                o_fail_count
);

    typedef struct {
        logic [7:0] data;
        logic       to_wire;
        logic       last;
    } t_out_byte;

    t_out_byte   due_bytes[$];
    t_out_byte   step_bytes[$];
    t_pstate     parse_st    = PS_DATA;
    logic [7:0]  verb_seen   = 8'h00;
    logic        naws_agreed = 1'b0;
    logic [15:0] cols        = COLS_RESET;
    logic [15:0] rows        = ROWS_RESET;
    int          due_count   = 0;
    int          fails       = 0;

    assign o_due_count  = due_count;
    assign o_fail_count = fails;

    function automatic void emit(input logic [7:0] b, input logic to_wire);
        t_out_byte item;
        item = '{data: b, to_wire: to_wire, last: 1'b0};
        step_bytes.insert(step_bytes.size(), item);
    endfunction

    function automatic void emit_window_size();
        emit(B_IAC, 1'b1);
        emit(B_SB, 1'b1);
        emit(O_NAWS, 1'b1);
        emit(cols[15:8], 1'b1);
        emit(cols[7:0], 1'b1);
        emit(rows[15:8], 1'b1);
        emit(rows[7:0], 1'b1);
        emit(B_IAC, 1'b1);
        emit(B_SE, 1'b1);
    endfunction

    function automatic void answer_option(input logic [7:0] opt);
        logic [7:0] verb;
        verb = 8'h00;
        case (verb_seen)
            B_DO: begin
                if (opt == O_NAWS) begin
                    emit(B_IAC, 1'b1);
                    emit(B_WILL, 1'b1);
                    emit(opt, 1'b1);
                    naws_agreed = 1'b1;
                    emit_window_size();
                    return;
                end
                verb = B_WONT;
            end
            B_WILL:  verb = (opt == O_ECHO || opt == O_SGA) ? B_DO : B_DONT;
            B_DONT:  verb = B_WONT;
            B_WONT:  verb = B_DONT;
            default: return;
        endcase
        emit(B_IAC, 1'b1);
        emit(verb, 1'b1);
        emit(opt, 1'b1);
    endfunction

    function automatic void predict_replies(input t_kind kind, input logic [7:0] b);
        step_bytes.delete();
        case (kind)
            KIND_RESIZE: begin
                if (naws_agreed) emit_window_size();
            end
            KIND_START: begin
                parse_st    = PS_DATA;
                verb_seen   = 8'h00;
                naws_agreed = 1'b0;
                emit(B_IAC, 1'b1);
                emit(B_WILL, 1'b1);
                emit(O_NAWS, 1'b1);
            end
            KIND_BYTE: begin
                case (parse_st)
                    PS_IAC: begin
                        if (b == B_IAC) begin
                            emit(B_IAC, 1'b0);
                            parse_st = PS_DATA;
                        end else if (b == B_SB) begin
                            parse_st = PS_SBHD;
                        end else if (b == B_DO || b == B_DONT || b == B_WILL || b == B_WONT) begin
                            verb_seen = b;
                            parse_st  = PS_CMD;
                        end else begin
                            parse_st = PS_DATA;
                        end
                    end
                    PS_CMD: begin
                        answer_option(b);
                        parse_st = PS_DATA;
                    end
                    PS_SBHD:  parse_st = PS_SBDAT;
                    PS_SBDAT: begin
                        if (b == B_IAC) parse_st = PS_SBIAC;
                    end
                    PS_SBIAC: parse_st = (b == B_IAC) ? PS_SBDAT : PS_DATA;
                    default: begin
                        if (b == B_IAC) begin
                            parse_st = PS_IAC;
                        end else begin
                            parse_st = PS_DATA;
                            emit(b, 1'b0);
                        end
                    end
                endcase
            end
            default: ;
        endcase
        if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last = 1'b1;
        foreach (step_bytes[i]) due_bytes.insert(due_bytes.size(), step_bytes[i]);
    endfunction

    function automatic void check_word();
        t_out_byte want;
        if (due_bytes.size() == 0) begin
            $error("unexpected word: out_byte %02h to_wire %0b last %0b",
                   i_m_tdata, i_m_tuser, i_m_tlast);
            fails++;
            return;
        end
        want = due_bytes.pop_front();
        if (i_m_tdata !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, i_m_tdata);
            fails++;
        end
        if (i_m_tuser !== want.to_wire) begin
            $error("to_wire: expected %0b, actual %0b", want.to_wire, i_m_tuser);
            fails++;
        end
        if (i_m_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, i_m_tlast);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_st    = PS_DATA;
            verb_seen   = 8'h00;
            naws_agreed = 1'b0;
            cols        = COLS_RESET;
            rows        = ROWS_RESET;
            due_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_IDX_COLS) cols = i_cfg_wdata;
                else rows = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) predict_replies(t_kind'(i_s_tuser), i_s_tdata);
            if (i_m_tvalid && i_m_tready) check_word();
        end
        due_count <= due_bytes.size();
    end

endmodule

// ===== test/telnet_rx_option_negotiator_core_test.sv =====
// ----------------------------------------------------------------------------
// Telnet RX option negotiator - testbench top
// Drives received bytes, resize and session start words into the core in
// random bursts while the output side stalls on its own pattern. A directed
// pass covers the IAC escape, DO NAWS, option replies and subnegotiation;
// random telnet traffic follows under several window sizes, extremes
// included. The checker instance predicts and compares every output word.
// ----------------------------------------------------------------------------
module telnet_rx_option_negotiator_core_test;
    import tnrx_pkg::*;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = CFG_IDX_COLS;
    logic [15:0]       cfg_wdata = 16'h0000;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = 8'h00;
    logic [1:0]        s_tuser   = KIND_BYTE;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    int                due_count;
    int                fail_count;
    int                burst_left = 0;
    int                items_sent = 0;
    int                rx_span    = 0;
    int                rx_mode    = 0;

    telnet_rx_option_negotiator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    telnet_rx_negotiation_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_due_count  (due_count),
        .o_fail_count (fail_count)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_span <= $urandom_range(8, 80);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 0);
            2:       m_tready <= (rx_span[1:0] == 2'b00);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_word(input t_kind k, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(20, 60);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 8);
                gap        = $urandom_range(1, 6);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    task automatic write_size(input logic [15:0] cols, input logic [15:0] rows);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_IDX_COLS;
        cfg_wdata <= cols;
        @(posedge clk);
        cfg_addr  <= CFG_IDX_ROWS;
        cfg_wdata <= rows;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // drain all expected words, then hold off for words the core may still emit
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (due_count != 0);
        repeat (32) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_option();
        case ($urandom_range(0, 3))
            0:       return O_NAWS;
            1:       return O_ECHO;
            2:       return O_SGA;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_verb();
        case ($urandom_range(0, 3))
            0:       return B_DO;
            1:       return B_DONT;
            2:       return B_WILL;
            default: return B_WONT;
        endcase
    endfunction

    task automatic send_telnet_sequence();
        int         pick;
        int         len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_word(KIND_BYTE, 8'($urandom_range(0, 254)));
        end else if (pick < 40) begin
            send_word(KIND_BYTE, B_IAC);
            send_word(KIND_BYTE, B_IAC);
        end else if (pick < 65) begin
            send_word(KIND_BYTE, B_IAC);
            send_word(KIND_BYTE, pick_verb());
            send_word(KIND_BYTE, pick_option());
        end else if (pick < 75) begin
            send_word(KIND_BYTE, B_IAC);
            send_word(KIND_BYTE, B_SB);
            send_word(KIND_BYTE, pick_option());
            len = $urandom_range(0, 4);
            repeat (len) begin
                b = 8'($urandom_range(0, 255));
                send_word(KIND_BYTE, b);
                if (b == B_IAC) send_word(KIND_BYTE, B_IAC);
            end
            send_word(KIND_BYTE, B_IAC);
            send_word(KIND_BYTE, B_SE);
        end else if (pick < 80) begin
            send_word(KIND_BYTE, B_IAC);
            send_word(KIND_BYTE, 8'($urandom_range(0, 8'hF9)));
        end else if (pick < 85) begin
            send_word(KIND_BYTE, B_IAC);
            send_word(KIND_BYTE, B_SB);
            send_word(KIND_BYTE, pick_option());
            send_word(KIND_BYTE, 8'($urandom_range(0, 254)));
            send_word(KIND_BYTE, B_IAC);
            send_word(KIND_BYTE, 8'($urandom_range(0, 8'hEF)));
        end else if (pick < 91) begin
            send_word(KIND_RESIZE, 8'($urandom_range(0, 255)));
        end else if (pick < 94) begin
            send_word(KIND_START, 8'($urandom_range(0, 255)));
        end else if (pick < 97) begin
            send_word(KIND_NONE, 8'($urandom_range(0, 255)));
        end else begin
            send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = items_sent + count;
        while (items_sent < goal) send_telnet_sequence();
    endtask

    initial begin
        logic [7:0] opening[6] = '{8'h00, B_IAC, B_IAC, B_IAC, B_DO, O_NAWS};
        logic [7:0] options[17] = '{B_IAC, B_WILL, O_ECHO, B_IAC, B_DONT, 8'hFF,
                                    B_IAC, B_SB, O_NAWS, B_IAC, B_IAC, B_IAC, B_SE,
                                    B_IAC, 8'hF1, 8'h7F, 8'hFE};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(KIND_START, 8'h00);
        send_word(KIND_RESIZE, 8'hFF);
        foreach (opening[i]) send_word(KIND_BYTE, opening[i]);
        send_word(KIND_RESIZE, 8'h00);
        foreach (options[i]) send_word(KIND_BYTE, options[i]);
        send_word(KIND_NONE, 8'hFF);
        settle();

        write_size(16'hFFFF, 16'h0001);
        run_random(30);
        settle();
        write_size(16'h0000, 16'h0000);
        run_random(30);
        settle();
        write_size(16'h0001, 16'hFFFF);
        run_random(30);
        settle();
        write_size(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        run_random(30);
        settle();

        if (fail_count == 0) begin
            $display("telnet_rx_option_negotiator_core regression: pass");
        end else begin
            $display("telnet_rx_option_negotiator_core regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("telnet_rx_option_negotiator_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tnrx_pkg.sv
rtl/core/tnrx_front.sv
rtl/core/tnrx_fifo.sv
rtl/core/tnrx_back.sv
rtl/core/telnet_rx_option_negotiator_core.sv
test/telnet_rx_negotiation_checker.sv
test/telnet_rx_option_negotiator_core_test.sv
